/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVP_ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define SVP_ASSERT(lbl, prop) `SVP_ASSERT_AT(lbl, clk_i, rst_ni, prop)
`else
`define SVP_ASSERT_AT(lbl, clk, rstn, prop)
`define SVP_ASSERT(lbl, prop)
`endif
`endif

/* rtl/core/svp_pkg.sv */
`timescale 1ns / 1ps
package svp_pkg;

  localparam int unsigned VelW  = 24;
  localparam int unsigned HalfW = 16;
  localparam int unsigned SshQW = 31;
  localparam int unsigned VelQW = 24;

  localparam logic [1:0] ST_PERTURBED = 2'd0;
  localparam logic [1:0] ST_PASS      = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;

  typedef enum logic [2:0] {
    CFG_SCALE,
    CFG_TAPER_START,
    CFG_END_DEPTH,
    CFG_VP_LIMIT,
    CFG_VS_LIMIT,
    CFG_WATER
  } svp_cfg_e;

  typedef struct packed {
    logic            pass;
    logic [VelW-1:0] vp;
    logic [VelW-1:0] vs;
    logic [VelW-1:0] rho;
  } svp_item_t;

  typedef struct packed {
    logic [HalfW-1:0] rem;
    logic [SshQW-1:0] dvd;
    logic [SshQW-1:0] quo;
    logic [HalfW-1:0] den;
    logic             neg;
  } svp_sdiv_t;

  typedef struct packed {
    logic [31:0]      d;
    logic [31:0]      remp;
    logic [31:0]      rems;
    logic [VelQW-1:0] qp;
    logic [VelQW-1:0] qs;
    logic             ovp;
    logic             ovs;
    logic             sat;
    logic [VelW-1:0]  rho_res;
  } svp_vdiv_t;

endpackage

/* rtl/core/svp_sdiv_cell.sv */
`timescale 1ns / 1ps
module svp_sdiv_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  svp_pkg::svp_item_t item_i,
  input  svp_pkg::svp_sdiv_t div_i,
  output logic               valid_o,
  output svp_pkg::svp_item_t item_o,
  output svp_pkg::svp_sdiv_t div_o
);
  import svp_pkg::*;

  logic               valid_q;
  svp_item_t          item_q;
  svp_sdiv_t          div_q, div_d;
  logic [HalfW:0]     trial;
  logic [HalfW:0]     diff;
  logic               ge;

  always_comb begin
    trial = {div_i.rem, div_i.dvd[SshQW-1]};
    ge    = trial >= {1'b0, div_i.den};
    diff  = trial - {1'b0, div_i.den};
    div_d = div_i;
    div_d.rem = ge ? diff[HalfW-1:0] : trial[HalfW-1:0];
    div_d.dvd = {div_i.dvd[SshQW-2:0], 1'b0};
    div_d.quo = {div_i.quo[SshQW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
    div_q  <= div_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign div_o   = div_q;
endmodule

/* rtl/core/svp_vdiv_cell.sv */
`timescale 1ns / 1ps
module svp_vdiv_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  svp_pkg::svp_item_t item_i,
  input  svp_pkg::svp_vdiv_t div_i,
  output logic               valid_o,
  output svp_pkg::svp_item_t item_o,
  output svp_pkg::svp_vdiv_t div_o
);
  import svp_pkg::*;

  logic        valid_q;
  svp_item_t   item_q;
  svp_vdiv_t   div_q, div_d;
  logic [32:0] tp, ts, dp, ds;
  logic        gp, gs;

  always_comb begin
    tp = {div_i.remp, 1'b0};
    ts = {div_i.rems, 1'b0};
    gp = tp >= {1'b0, div_i.d};
    gs = ts >= {1'b0, div_i.d};
    dp = tp - {1'b0, div_i.d};
    ds = ts - {1'b0, div_i.d};
    div_d = div_i;
    div_d.remp = gp ? dp[31:0] : tp[31:0];
    div_d.rems = gs ? ds[31:0] : ts[31:0];
    div_d.qp   = {div_i.qp[VelQW-2:0], gp};
    div_d.qs   = {div_i.qs[VelQW-2:0], gs};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
    div_q  <= div_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign div_o   = div_q;
endmodule

/* rtl/core/seismic_velocity_perturb_top.sv */
`timescale 1ns / 1ps
// Each point passes stage 0, stage 1, a chain of 31 cells for the perturbation divide,
// prep, the multiply stage, 24 cells for the velocity divides and the output register.
// One quotient bit per cell. Throughput: one point per cycle; busy is never raised,
// the receiver cannot stall.
// Reset clears the valid chain and loads the configuration defaults.
module seismic_velocity_perturb_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] het_sample_i,
  input  logic [15:0] depth_layer_i,
  input  logic [23:0] vp_in_i,
  input  logic [23:0] vs_in_i,
  input  logic [23:0] rho_in_i,
  output logic        result_valid_o,
  output logic [23:0] vp_out_o,
  output logic [23:0] vs_out_o,
  output logic [23:0] rho_out_o,
  output logic [1:0]  point_status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import svp_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned Lat = 60;

  logic [15:0] scale_q, tstart_q, tend_q;
  logic [23:0] vp_lim_q, vs_lim_q, water_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 16'd6554;
      tstart_q <= 16'd937;
      tend_q   <= 16'd1250;
      vp_lim_q <= 24'd9728000;
      vs_lim_q <= 24'd6144000;
      water_q  <= 24'd0;
    end else if (cfg_valid_i) begin
      unique case (svp_cfg_e'(cfg_index_i))
        CFG_SCALE:       scale_q  <= cfg_data_i[15:0];
        CFG_TAPER_START: tstart_q <= cfg_data_i[15:0];
        CFG_END_DEPTH:   tend_q   <= cfg_data_i[15:0];
        CFG_VP_LIMIT:    vp_lim_q <= cfg_data_i;
        CFG_VS_LIMIT:    vs_lim_q <= cfg_data_i;
        CFG_WATER:       water_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // stage 0: scale times sample magnitude, taper terms
  logic        v0_q;
  svp_item_t   it0_q;
  logic [30:0] scm0_q;
  logic [15:0] num0_q, den0_q;
  logic        neg0_q;
  logic [15:0] smag;
  logic        taper;
  logic [31:0] scm_full;

  always_comb begin
    smag     = het_sample_i[15] ? (16'd0 - het_sample_i) : het_sample_i;
    taper    = depth_layer_i >= tstart_q;
    scm_full = scale_q * smag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    it0_q.pass <= (depth_layer_i >= tend_q) || (vs_in_i <= water_q);
    it0_q.vp   <= vp_in_i;
    it0_q.vs   <= vs_in_i;
    it0_q.rho  <= rho_in_i;
    scm0_q     <= scm_full[30:0];
    num0_q     <= taper ? (tend_q - depth_layer_i - 16'd1) : 16'd1;
    den0_q     <= taper ? (tend_q - tstart_q) : 16'd1;
    neg0_q     <= het_sample_i[15];
  end

  // stage 1: full product magnitude
  logic        v1_q;
  svp_item_t   it1_q;
  logic [46:0] pm1_q;
  logic [15:0] den1_q;
  logic        neg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it1_q  <= it0_q;
    pm1_q  <= scm0_q * num0_q;
    den1_q <= den0_q;
    neg1_q <= neg0_q;
  end

  logic      sv   [SshQW+1];
  svp_item_t sit  [SshQW+1];
  svp_sdiv_t sdv  [SshQW+1];

  assign sv[0]      = v1_q;
  assign sit[0]     = it1_q;
  assign sdv[0].rem = pm1_q[46:31];
  assign sdv[0].dvd = pm1_q[30:0];
  assign sdv[0].quo = '0;
  assign sdv[0].den = den1_q;
  assign sdv[0].neg = neg1_q;

  for (genvar g = 0; g < SshQW; g++) begin : g_sdiv
    svp_sdiv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv[g]),
      .item_i (sit[g]),
      .div_i  (sdv[g]),
      .valid_o(sv[g+1]),
      .item_o (sit[g+1]),
      .div_o  (sdv[g+1])
    );
  end

  // prep: signed perturbation, denominator and density factor
  logic        vpr_q;
  svp_item_t   itp_q;
  logic [31:0] dp_q, fp_q;
  logic        satp_q, fnegp_q;
  logic [31:0] ssh;
  logic [32:0] d28, f28;

  always_comb begin
    ssh = sdv[SshQW].neg ? (32'd0 - {1'b0, sdv[SshQW].quo}) : {1'b0, sdv[SshQW].quo};
    d28 = 33'h010000000 - {ssh[31], ssh};
    f28 = 33'h010000000 + {ssh[31], ssh};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpr_q <= 1'b0;
    end else begin
      vpr_q <= sv[SshQW];
    end
  end

  always_ff @(posedge clk_i) begin
    itp_q   <= sit[SshQW];
    dp_q    <= d28[31:0];
    fp_q    <= f28[31:0];
    satp_q  <= d28[32] || (d28 == 33'd0);
    fnegp_q <= f28[32] || (f28 == 33'd0);
  end

  // multiply stage: density product, overflow checks
  logic        vm_q;
  svp_item_t   itm_q;
  logic [55:0] rprod_q;
  logic [31:0] dm_q;
  logic        satm_q, fnegm_q, ovp_q, ovs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= vpr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    itm_q   <= itp_q;
    rprod_q <= itp_q.rho * fp_q;
    dm_q    <= dp_q;
    satm_q  <= satp_q;
    fnegm_q <= fnegp_q;
    ovp_q   <= {4'd0, itp_q.vp, 4'd0} >= dp_q;
    ovs_q   <= {4'd0, itp_q.vs, 4'd0} >= dp_q;
  end

  logic      vv  [VelQW+1];
  svp_item_t vit [VelQW+1];
  svp_vdiv_t vdv [VelQW+1];

  assign vv[0]          = vm_q;
  assign vit[0]         = itm_q;
  assign vdv[0].d       = dm_q;
  assign vdv[0].remp    = {4'd0, itm_q.vp, 4'd0};
  assign vdv[0].rems    = {4'd0, itm_q.vs, 4'd0};
  assign vdv[0].qp      = '0;
  assign vdv[0].qs      = '0;
  assign vdv[0].ovp     = ovp_q;
  assign vdv[0].ovs     = ovs_q;
  assign vdv[0].sat     = satm_q;
  assign vdv[0].rho_res = fnegm_q ? 24'd0 :
                          (|rprod_q[55:52]) ? 24'hFFFFFF : rprod_q[51:28];

  for (genvar g = 0; g < VelQW; g++) begin : g_vdiv
    svp_vdiv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vv[g]),
      .item_i (vit[g]),
      .div_i  (vdv[g]),
      .valid_o(vv[g+1]),
      .item_o (vit[g+1]),
      .div_o  (vdv[g+1])
    );
  end

  // output register
  svp_item_t fi;
  svp_vdiv_t fd;
  logic      rv_q;
  logic [23:0] vpo_q, vso_q, rhoo_q;
  logic [1:0]  st_q;

  assign fi = vit[VelQW];
  assign fd = vdv[VelQW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= vv[VelQW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fi.pass) begin
      vpo_q  <= fi.vp;
      vso_q  <= fi.vs;
      rhoo_q <= fi.rho;
      st_q   <= ST_PASS;
    end else begin
      vpo_q  <= (fd.sat || fd.ovp || (fd.qp > vp_lim_q)) ? vp_lim_q : fd.qp;
      vso_q  <= (fd.sat || fd.ovs || (fd.qs > vs_lim_q)) ? vs_lim_q : fd.qs;
      rhoo_q <= fd.rho_res;
      st_q   <= fd.sat ? ST_SAT : ST_PERTURBED;
    end
  end

  assign result_valid_o = rv_q;
  assign vp_out_o       = vpo_q;
  assign vs_out_o       = vso_q;
  assign rho_out_o      = rhoo_q;
  assign point_status_o = st_q;

  `SVP_ASSERT(a_latency, start |-> ##Lat result_valid_o)
  `SVP_ASSERT(a_status_code, result_valid_o |-> (point_status_o == ST_PERTURBED || point_status_o == ST_PASS || point_status_o == ST_SAT))
  `SVP_ASSERT(a_sat_limits, (result_valid_o && point_status_o == ST_SAT) |-> (vp_out_o == vp_lim_q && vs_out_o == vs_lim_q))
  `SVP_ASSERT(a_vp_clamped, (result_valid_o && point_status_o != ST_PASS) |-> (vp_out_o <= vp_lim_q && vs_out_o <= vs_lim_q))
endmodule
